// ===== rtl/core/lcg_pkg.sv =====
// Package for the chirp sample generator: payload words, register indexes,
// reset values and the sine table entry function. No dependencies.
`timescale 1ns / 1ps

package lcg_pkg;

    // Defaults for the top-level parameters
    localparam int MAX_SF_DEFAULT      = 12;
    localparam int TABLE_BITS_DEFAULT  = 10;
    localparam int SAMPLE_BITS_DEFAULT = 16;

    localparam int MIN_SF      = 7;
    localparam int PHASE_W     = 32;
    localparam int FRAC_W      = 16;
    localparam int SYMBOL_W    = 12;
    localparam int SF_W        = 4;
    localparam int SPS_W       = 16;
    localparam int BW_W        = 17;
    localparam int OFS_W       = 16;
    localparam int OUT_W       = 16;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 17;

    localparam logic [SF_W-1:0]  SF_RESET  = 4'd7;
    localparam logic [SPS_W-1:0] SPS_RESET = 16'd128;
    localparam logic [BW_W-1:0]  BW_ONE    = 17'h10000;
    localparam logic [OFS_W-1:0] OFS_RESET = 16'd0;

    // pi/2 in Q30
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam logic [63:0] ONE_Q30     = 64'd1 << 30;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_SPREADING_FACTOR   = 2'd0,
        REG_SAMPLES_PER_SYMBOL = 2'd1,
        REG_BANDWIDTH_RATIO    = 2'd2,
        REG_OFFSET_RATIO       = 2'd3
    } cfg_reg_t;

    localparam logic CMD_START = 1'b0;
    localparam logic CMD_NEXT  = 1'b1;

    typedef struct packed {
        logic                command;
        logic [SYMBOL_W-1:0] symbol;
        logic                inverse;
    } cmd_word_t;

    typedef struct packed {
        logic signed [OUT_W-1:0] in_phase;
        logic signed [OUT_W-1:0] quadrature;
        logic signed [OUT_W-1:0] phase_angle;
        logic [OUT_W-1:0]        sample_index;
        logic                    last_sample;
    } sample_word_t;

    // Shift-and-subtract quotient of two 64-bit values. Elaboration only.
    function automatic logic [63:0] long_quotient(logic [63:0] num, logic [63:0] den);
        logic [63:0] quo;
        logic [64:0] rem;
        quo = '0;
        rem = '0;
        for (int b = 63; b >= 0; b--)
        begin
            rem = {rem[63:0], num[b]};
            if (rem >= {1'b0, den})
            begin
                rem    = rem - {1'b0, den};
                quo[b] = 1'b1;
            end
        end
        return quo;
    endfunction

    // One quarter-wave table entry: sin(pi/2 * k / 2^tab_bits) at full scale,
    // integer Taylor series in Q30, rounded and clamped. Elaboration only.
    function automatic logic [31:0] sine_entry(int unsigned k, int unsigned tab_bits,
                                               int unsigned sample_bits);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] sum;
        logic [63:0] full;
        logic [63:0] e;
        logic [63:0] divisor;
        x    = (HALF_PI_Q30 * 64'(k)) >> tab_bits;
        x2   = (x * x) >> 30;
        term = x;
        sum  = x;
        full = (64'd1 << (sample_bits - 1)) - 64'd1;
        for (int n = 1; n <= 12; n++)
        begin
            divisor = 64'((2 * n) * (2 * n + 1));
            term    = (term * x2) >> 30;
            term    = long_quotient(term, divisor);
            if (n[0])
                sum = sum - term;
            else
                sum = sum + term;
        end
        e = (sum * full + (ONE_Q30 >> 1)) >> 30;
        if (e > full)
            e = full;
        return 32'(e);
    endfunction

endpackage

// ===== rtl/core/lora_chirp_generator.sv =====
// LoRa chirp sample generator top level: phase/chip-shift datapath, quarter-wave
// sine ROM and output register. Depends on lcg_pkg.
`timescale 1ns / 1ps
//
//  channel  | signals                              | direction | word
//  ---------+--------------------------------------+-----------+------------------
//  req      | req_valid, req_ready, req_word       | in        | cmd_word_t
//  smp      | smp_valid, smp_ready, smp_word       | out       | sample_word_t
//  cfg      | cfg_valid, cfg_ready, cfg_index/data | in        | register write
//
//  One command word in, one sample word out; a new word is taken every clock while
//  the output is not stalled. The phase, shift and counter update together with
//  the sine ROM read in the accept cycle, and the quadrant sign and scaling then
//  land in the output register. The 17 x (MAX_SPREADING_FACTOR+16)
//  multiply feeding the phase accumulator sets the clock period.
//  Reset clears the symbol state and loads register defaults; no clearing pass.
//  A stalled output holds the sample; one more word is absorbed into the ROM
//  stage, then req_ready drops until smp_ready returns.

module lora_chirp_generator
    import lcg_pkg::*;
#(
    parameter int MAX_SPREADING_FACTOR = MAX_SF_DEFAULT,
    parameter int TABLE_ADDRESS_BITS   = TABLE_BITS_DEFAULT,
    parameter int SAMPLE_BITS          = SAMPLE_BITS_DEFAULT
)
(
    input  logic                   clk,
    input  logic                   rst_n,

    input  logic                   req_valid,
    output logic                   req_ready,
    input  cmd_word_t              req_word,

    output logic                   smp_valid,
    input  logic                   smp_ready,
    output sample_word_t           smp_word,

    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    // Chip shift is Q(SF).16 chips, sized for the largest spreading factor
    localparam int SHIFT_W     = MAX_SPREADING_FACTOR + FRAC_W;
    localparam int PROD_W      = BW_W + SHIFT_W;
    localparam int QUARTER     = 1 << TABLE_ADDRESS_BITS;
    localparam int ADDR_W      = TABLE_ADDRESS_BITS + 1;
    localparam int MAG_W       = SAMPLE_BITS - 1;

    typedef logic [MAG_W-1:0] sine_rom_t [0:QUARTER];

    function automatic sine_rom_t build_rom();
        sine_rom_t rom;
        for (int k = 0; k <= QUARTER; k++)
        begin
            rom[k] = MAG_W'(sine_entry(k, TABLE_ADDRESS_BITS, SAMPLE_BITS));
        end
        return rom;
    endfunction

    localparam sine_rom_t SINE_ROM = build_rom();

    // Configuration registers
    logic [SF_W-1:0]  sf_reg;
    logic [SPS_W-1:0] sps_reg;
    logic [BW_W-1:0]  bw_reg;
    logic [OFS_W-1:0] ofs_reg;

    // Symbol state
    logic [PHASE_W-1:0] phase_reg,   phase_next;
    logic [SHIFT_W-1:0] shift_reg,   shift_next;
    logic [SPS_W-1:0]   counter_reg, counter_next;
    logic               down_reg,    down_next;

    // ROM stage
    logic               s1_valid_reg;
    logic [MAG_W-1:0]   cos_mag_reg;
    logic [MAG_W-1:0]   sin_mag_reg;
    logic               cos_neg_reg;
    logic               sin_neg_reg;
    logic [OUT_W-1:0]   angle_reg;
    logic [SPS_W-1:0]   index_reg;
    logic               last_reg;

    // Output stage
    logic               smp_valid_reg;
    sample_word_t       smp_word_reg;

    logic               accept;
    logic               out_free;

    // Per-item datapath
    logic [SF_W-1:0]             sf_act;
    logic [BW_W-1:0]             bw_sat;
    logic [SYMBOL_W-1:0]         sym_masked;
    logic [SHIFT_W-1:0]          shift_mask;
    logic [PHASE_W-1:0]          phase_cur;
    logic [SHIFT_W-1:0]          shift_cur;
    logic [SPS_W-1:0]            counter_cur;
    logic                        down_cur;
    logic [SPS_W-1:0]            last_index;
    logic                        is_last;
    logic [PROD_W-1:0]           product;
    logic [PHASE_W-1:0]          sweep_inc;
    logic [PHASE_W-1:0]          inc;
    logic [1:0]                  sin_quad;
    logic [1:0]                  cos_quad;
    logic [TABLE_ADDRESS_BITS-1:0] table_idx;
    logic [ADDR_W-1:0]           sin_addr;
    logic [ADDR_W-1:0]           cos_addr;

    // Scaling in the output stage
    logic [MAG_W+7:0]            cos_wide;
    logic [MAG_W+7:0]            sin_wide;
    logic [OUT_W-1:0]            cos_scaled;
    logic [OUT_W-1:0]            sin_scaled;
    sample_word_t                smp_word_next;

    // Handshakes: the ROM stage moves on whenever the output register frees up
    assign out_free  = !smp_valid_reg || smp_ready;
    assign req_ready = !s1_valid_reg || out_free;
    assign accept    = req_valid && req_ready;
    assign cfg_ready = 1'b1;
    assign smp_valid = smp_valid_reg;
    assign smp_word  = smp_word_reg;

    // Register writes; indexes are all defined, the enum covers the port
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sf_reg  <= SF_RESET;
            sps_reg <= SPS_RESET;
            bw_reg  <= BW_ONE;
            ofs_reg <= OFS_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_SPREADING_FACTOR:   sf_reg  <= cfg_data[SF_W-1:0];
                REG_SAMPLES_PER_SYMBOL: sps_reg <= cfg_data[SPS_W-1:0];
                REG_BANDWIDTH_RATIO:    bw_reg  <= cfg_data[BW_W-1:0];
                REG_OFFSET_RATIO:       ofs_reg <= cfg_data[OFS_W-1:0];
                default:                sf_reg  <= sf_reg;
            endcase
        end
    end

    // Clamp SF to the supported range, saturate bandwidth at one
    always_comb
    begin
        if (sf_reg < SF_W'(MIN_SF))
            sf_act = SF_W'(MIN_SF);
        else if (sf_reg > SF_W'(MAX_SPREADING_FACTOR))
            sf_act = SF_W'(MAX_SPREADING_FACTOR);
        else
            sf_act = sf_reg;
        bw_sat = bw_reg[BW_W-1] ? BW_ONE : bw_reg;
    end

    always_comb
    begin
        for (int i = 0; i < SYMBOL_W; i++)
        begin
            sym_masked[i] = req_word.symbol[i] && (i < int'(sf_act));
        end
        for (int i = 0; i < SHIFT_W; i++)
        begin
            shift_mask[i] = (i < int'(sf_act) + FRAC_W);
        end
    end

    // A start word loads the symbol and clears the phase before this sample
    always_comb
    begin
        if (req_word.command == CMD_START)
        begin
            phase_cur   = '0;
            shift_cur   = SHIFT_W'({sym_masked, {FRAC_W{1'b0}}});
            counter_cur = '0;
            down_cur    = req_word.inverse;
        end
        else
        begin
            phase_cur   = phase_reg;
            shift_cur   = shift_reg;
            counter_cur = counter_reg;
            down_cur    = down_reg;
        end
    end

    // Phase increment: bw * shift / 2^SF, mirrored for a down-chirp, plus offset
    always_comb
    begin
        last_index   = sps_reg - SPS_W'(1);
        is_last      = (counter_cur == last_index);
        product      = PROD_W'(bw_sat) * PROD_W'(shift_cur);
        sweep_inc    = PHASE_W'(product >> sf_act);
        if (down_cur)
            inc = PHASE_W'({bw_sat, {FRAC_W{1'b0}}}) - sweep_inc;
        else
            inc = sweep_inc;
        inc          = inc + {ofs_reg, {FRAC_W{1'b0}}};
        phase_next   = phase_cur + inc;
        shift_next   = (shift_cur + SHIFT_W'(bw_sat)) & shift_mask;
        counter_next = is_last ? '0 : counter_cur + SPS_W'(1);
        down_next    = down_cur;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= '0;
            shift_reg   <= '0;
            counter_reg <= '0;
            down_reg    <= 1'b0;
        end
        else if (accept)
        begin
            phase_reg   <= phase_next;
            shift_reg   <= shift_next;
            counter_reg <= counter_next;
            down_reg    <= down_next;
        end
    end

    // Quarter-wave addressing; cosine is the sine a quarter turn ahead
    always_comb
    begin
        sin_quad  = phase_cur[PHASE_W-1 -: 2];
        cos_quad  = sin_quad + 2'd1;
        table_idx = phase_cur[PHASE_W-3 -: TABLE_ADDRESS_BITS];
        sin_addr  = sin_quad[0] ? ADDR_W'(QUARTER) - ADDR_W'(table_idx) : ADDR_W'(table_idx);
        cos_addr  = cos_quad[0] ? ADDR_W'(QUARTER) - ADDR_W'(table_idx) : ADDR_W'(table_idx);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (req_ready)
            s1_valid_reg <= req_valid;
    end

    // ROM read with registered data
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            sin_mag_reg <= SINE_ROM[sin_addr];
            cos_mag_reg <= SINE_ROM[cos_addr];
            sin_neg_reg <= sin_quad[1];
            cos_neg_reg <= cos_quad[1];
            angle_reg   <= phase_cur[PHASE_W-1 -: OUT_W];
            index_reg   <= counter_cur;
            last_reg    <= is_last;
        end
    end

    // Scale the magnitude to Q1.15 and apply the quadrant sign
    always_comb
    begin
        cos_wide   = {cos_mag_reg, 8'b0};
        sin_wide   = {sin_mag_reg, 8'b0};
        cos_scaled = OUT_W'(cos_wide >> (SAMPLE_BITS - 8));
        sin_scaled = OUT_W'(sin_wide >> (SAMPLE_BITS - 8));
        smp_word_next.in_phase     = cos_neg_reg ? -cos_scaled : cos_scaled;
        smp_word_next.quadrature   = sin_neg_reg ? -sin_scaled : sin_scaled;
        smp_word_next.phase_angle  = angle_reg;
        smp_word_next.sample_index = index_reg;
        smp_word_next.last_sample  = last_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            smp_valid_reg <= 1'b0;
        else if (out_free)
            smp_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (out_free && s1_valid_reg)
            smp_word_reg <= smp_word_next;
    end

endmodule
